FILE: hdl/bma_pkg.sv
// Shared codes, widths and handshake structs for the block map allocator.
// Depends on nothing; imported by bma_div and block_map_allocator.
`default_nettype none

package bma_pkg;

  localparam int ADDR_W   = 32;
  localparam int BYTES_W  = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 11;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL = 2'd2;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/bma_map_ram.sv
// Owner map storage: one write port and one registered read port.
// Depends on nothing; instantiated by block_map_allocator.
`default_nettype none

module bma_map_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one entry into the registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/bma_div.sv
// Divider by a constant through a reciprocal multiply; start is registered into pend, then done.
// Depends on bma_pkg; instantiated by block_map_allocator.
`default_nettype none

module bma_div
  import bma_pkg::*;
#(
  parameter int DIVISOR = 32,
  parameter int DVD_W   = 17
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  // floor(x / DIVISOR) = (x * RECIP) >> SHIFT for every x below 2**DVD_W
  localparam int SHIFT = DVD_W + $clog2(DIVISOR);
  localparam int RCP_W = DVD_W + 2;
  localparam int PRD_W = DVD_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << SHIFT) / DIVISOR) + 64'd1);

  logic             pend_q;
  logic             done_q;
  logic [DVD_W-1:0] dvd_q;
  logic [PRD_W-1:0] prod_q, prod_d;

  assign prod_d = PRD_W'(dvd_q) * PRD_W'(RECIP);

  // Advance start through the dividend and product stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= req_i.start;
      done_q <= pend_q;
    end
  end

  // Capture the dividend, then the scaled product
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend[DVD_W-1:0];
    end
    if (pend_q) begin
      prod_q <= prod_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = ADDR_W'(prod_q[PRD_W-1:SHIFT]);

endmodule

`default_nettype wire

FILE: hdl/block_map_allocator.sv
// Block map allocator; one transaction at a time, the input stalls until the result loads.
// Allocate: the divider sizes the request, then a top-down scan of one entry per cycle
// counts the free run, the run is marked and the result register loads once it is free.
// Release: the divider gives the index, the map returns the count, the run is cleared, then the result loads.
// Reset clears control state only; init and the first allocate or non-null release sweep
// the map clear. Depends on bma_pkg, bma_div and bma_map_ram.
`default_nettype none

module block_map_allocator
  import bma_pkg::*;
#(
  parameter int BLOCK_BYTES = 32,
  parameter int MAP_ENTRIES = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [ADDR_W-1:0]   cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     opcode_i,
  input  wire logic [BYTES_W-1:0]  request_bytes_i,
  input  wire logic [ADDR_W-1:0]   release_address_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [ADDR_W-1:0]   address_o,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [FREE_W-1:0]   free_blocks_o
);

  localparam int IW = $clog2(MAP_ENTRIES);
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam int POOL_W = $clog2(MAP_ENTRIES * BLOCK_BYTES);
  localparam int DVD_W  = (POOL_W > BYTES_W + 1) ? POOL_W : BYTES_W + 1;
  localparam logic [IW-1:0]     LAST_IDX  = IW'(MAP_ENTRIES - 1);
  localparam logic [CW-1:0]     FULL_CNT  = CW'(MAP_ENTRIES);
  localparam logic [ADDR_W-1:0] BLK       = ADDR_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] BLK_M1    = ADDR_W'(BLOCK_BYTES - 1);
  localparam logic [ADDR_W:0]   POOL_SIZE = (ADDR_W+1)'(MAP_ENTRIES * BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] BASE_RST  = 32'h6800_0000;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INIT     = 8'b0000_0010,
    S_DIV      = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_REL_RD   = 8'b0001_0000,
    S_REL_WAIT = 8'b0010_0000,
    S_FILL     = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Control state
  logic              ready_q, ready_d;
  logic [CW-1:0]     free_q, free_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] pool_base_q, pool_base_d;
  logic              issue_more_q, issue_more_d;
  logic              rd_pend_q, rd_pend_d;

  // Working payload
  logic [OP_W-1:0]     op_q, op_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;
  logic [CW-1:0]       need_q, need_d;
  logic [CW-1:0]       run_q, run_d;
  logic [CW-1:0]       left_q, left_d;
  logic [CW-1:0]       wdata_q, wdata_d;
  logic [IW-1:0]       wr_idx_q, wr_idx_d;
  logic [IW-1:0]       issue_idx_q, issue_idx_d;
  logic [IW-1:0]       didx_q, didx_d;
  logic [IW-1:0]       rel_idx_q, rel_idx_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  // Output register
  logic                out_load;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [FREE_W-1:0]   out_free_q;

  // Map port and divider
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  logic [ADDR_W-1:0] offset;
  logic [CW:0]       rel_sum;
  logic [CW-1:0]     run_n;

  assign offset  = release_address_i - pool_base_q;
  assign rel_sum = {1'b0, free_q} + {1'b0, ram_rdata};
  assign run_n   = (ram_rdata == '0) ? CW'(run_q + 1'b1) : '0;

  bma_map_ram #(
    .DEPTH (MAP_ENTRIES),
    .WIDTH (CW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bma_div #(
    .DIVISOR (BLOCK_BYTES),
    .DVD_W   (DVD_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer: the map is read only in scan and release-read, written only in
  // init and fill, so a read never overlaps a write to the same entry
  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    free_d       = free_q;
    out_valid_d  = out_valid_q;
    pool_base_d  = pool_base_q;
    issue_more_d = issue_more_q;
    rd_pend_d    = rd_pend_q;
    op_d         = op_q;
    bytes_d      = bytes_q;
    need_d       = need_q;
    run_d        = run_q;
    left_d       = left_q;
    wdata_d      = wdata_q;
    wr_idx_d     = wr_idx_q;
    issue_idx_d  = issue_idx_q;
    didx_d       = didx_q;
    rel_idx_d    = rel_idx_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wr_idx_q;
    ram_wdata    = wdata_q;
    ram_re       = 1'b0;
    ram_raddr    = issue_idx_q;
    div_req.start    = 1'b0;
    div_req.dividend = ADDR_W'(bytes_q) + BLK_M1;

    if (cfg_we_i) begin
      pool_base_d = cfg_wdata_i;
    end

    // Drop the result once the consumer takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = opcode_i;
          bytes_d    = request_bytes_i;
          res_addr_d = '0;
          wr_idx_d   = '0;
          case (opcode_i)
            OP_ALLOC: begin
              if (!ready_q) begin
                state_d = S_INIT;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = ADDR_W'(request_bytes_i) + BLK_M1;
                state_d          = S_DIV;
              end
            end
            OP_RELEASE: begin
              if (release_address_i == '0) begin
                res_status_d = ST_NULL;
                state_d      = S_RESULT;
              end else if (!ready_q) begin
                state_d = S_INIT;
              end else if ({1'b0, offset} >= POOL_SIZE) begin
                res_status_d = ST_FAIL;
                state_d      = S_RESULT;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = offset;
                state_d          = S_DIV;
              end
            end
            OP_INIT: begin
              state_d = S_INIT;
            end
            default: begin
              res_status_d = ST_FAIL;
              state_d      = S_RESULT;
            end
          endcase
        end
      end

      // Sweep the map clear, then start a pending allocate; a pending release fails, an init returns OK
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = wr_idx_q;
        ram_wdata = '0;
        if (wr_idx_q == LAST_IDX) begin
          ready_d = 1'b1;
          free_d  = FULL_CNT;
          case (op_q)
            OP_ALLOC: begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
            OP_RELEASE: begin
              res_status_d = ST_FAIL;
              state_d      = S_RESULT;
            end
            default: begin
              res_status_d = ST_OK;
              state_d      = S_RESULT;
            end
          endcase
        end else begin
          wr_idx_d = wr_idx_q + 1'b1;
        end
      end

      // Wait for block count (allocate) or block index (release)
      S_DIV: begin
        if (div_rsp.done) begin
          if (op_q == OP_ALLOC) begin
            if (bytes_q == '0 || div_rsp.quotient > ADDR_W'(free_q)) begin
              res_status_d = ST_FAIL;
              state_d      = S_RESULT;
            end else begin
              need_d       = CW'(div_rsp.quotient);
              issue_idx_d  = LAST_IDX;
              issue_more_d = 1'b1;
              rd_pend_d    = 1'b0;
              run_d        = '0;
              state_d      = S_SCAN;
            end
          end else begin
            rel_idx_d = IW'(div_rsp.quotient);
            state_d   = S_REL_RD;
          end
        end
      end

      // Read one entry per cycle from the top, count the free run
      S_SCAN: begin
        ram_re    = issue_more_q;
        ram_raddr = issue_idx_q;
        rd_pend_d = issue_more_q;
        if (issue_more_q) begin
          didx_d = issue_idx_q;
          if (issue_idx_q == '0) begin
            issue_more_d = 1'b0;
          end else begin
            issue_idx_d = issue_idx_q - 1'b1;
          end
        end
        if (rd_pend_q) begin
          run_d = run_n;
          if (run_n == need_q) begin
            issue_more_d = 1'b0;
            res_addr_d   = pool_base_q + ADDR_W'(didx_q) * BLK;
            res_status_d = ST_OK;
            free_d       = free_q - need_q;
            wr_idx_d     = didx_q;
            left_d       = need_q;
            wdata_d      = need_q;
            state_d      = S_FILL;
          end else if (didx_q == '0) begin
            issue_more_d = 1'b0;
            res_status_d = ST_FAIL;
            state_d      = S_RESULT;
          end
        end
      end

      S_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rel_idx_q;
        state_d   = S_REL_WAIT;
      end

      // Take the stored count, give it back to the free count
      S_REL_WAIT: begin
        left_d       = ram_rdata;
        wdata_d      = '0;
        wr_idx_d     = rel_idx_q;
        res_status_d = ST_OK;
        free_d       = (rel_sum > {1'b0, FULL_CNT}) ? FULL_CNT : rel_sum[CW-1:0];
        state_d      = S_FILL;
      end

      // Mark or clear a run, stopping at the top entry
      S_FILL: begin
        if (left_q == '0) begin
          state_d = S_RESULT;
        end else begin
          ram_we = 1'b1;
          if (wr_idx_q == LAST_IDX) begin
            state_d = S_RESULT;
          end else begin
            wr_idx_d = wr_idx_q + 1'b1;
            left_d   = left_q - 1'b1;
          end
        end
      end

      // Hold until the output register is free
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ready_q      <= 1'b0;
      free_q       <= FULL_CNT;
      out_valid_q  <= 1'b0;
      pool_base_q  <= BASE_RST;
      issue_more_q <= 1'b0;
      rd_pend_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      ready_q      <= ready_d;
      free_q       <= free_d;
      out_valid_q  <= out_valid_d;
      pool_base_q  <= pool_base_d;
      issue_more_q <= issue_more_d;
      rd_pend_q    <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    bytes_q      <= bytes_d;
    need_q       <= need_d;
    run_q        <= run_d;
    left_q       <= left_d;
    wdata_q      <= wdata_d;
    wr_idx_q     <= wr_idx_d;
    issue_idx_q  <= issue_idx_d;
    didx_q       <= didx_d;
    rel_idx_q    <= rel_idx_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
      out_free_q   <= FREE_W'(free_q);
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign address_o     = out_addr_q;
  assign status_o      = out_status_q;
  assign free_blocks_o = out_free_q;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FULL_CNT)
    else $error("free count above pool size");

  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("result presented outside result state");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");

  a_scan_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("map written during scan");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != S_IDLE)
    else $error("transaction accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire
